@@ sv/mmf_pkg.sv @@
package mmf_pkg;

    localparam int unsigned DATA_W = 16;

    typedef logic signed [DATA_W-1:0] sample_t;

    localparam sample_t FLOOR_RESET = -16'sd4370;

    // Contents of the register between the window stage and the output stage.
    typedef struct packed {
        logic    valid;
        logic    last;
        sample_t data;
    } stage_t;

endpackage

@@ sv/moving_median_filter_top.sv @@
// Channel   Direction  Beat contents
// s_*       input      tdata[15:0] = sample
// m_*       output     tdata[15:0] = value, tlast = end_of_run
// cfg_*     input      wr_data[15:0] = floor_value
//
// A sample beat is taken every cycle while s_tready is high; any result beat
// passes the window shift register and the output register, the two stages.
// The output beat is held while m_tready is low, and s_tready falls only when
// both stages are full. Reset is synchronous on aresetn and empties the window.
module moving_median_filter_top
    import mmf_pkg::*;
#(
    parameter int unsigned WINDOW = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] value
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    sample_t              floor_reg;
    sample_t [WINDOW-1:0] window;
    sample_t              median;
    stage_t               stage;
    logic                 advance;
    logic                 accept;
    logic                 m_tvalid_reg;
    logic                 m_tlast_reg;
    sample_t              m_tdata_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = !stage.valid || advance;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= FLOOR_RESET;
        end else if (cfg_wr_en) begin
            floor_reg <= cfg_wr_data;
        end
    end

    mmf_window #(
        .WINDOW(WINDOW)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .sample      (s_tdata),
        .floor_value (floor_reg),
        .advance     (advance),
        .window      (window),
        .stage       (stage)
    );

    mmf_median #(
        .WINDOW(WINDOW)
    ) u_median (
        .window (window),
        .median (median)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= stage.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tlast_reg <= stage.last;
            m_tdata_reg <= stage.last ? stage.data : median;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    a_term_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ($signed(s_tdata) < $signed(floor_reg))
        |=> stage.valid && stage.last && (stage.data == $past(s_tdata)))
        else $error("terminator beat not echoed into the stage register");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        stage.valid && advance |=> m_tvalid)
        else $error("stage beat lost on its way to the output register");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        stage.valid && !advance |-> !s_tready)
        else $error("sample beat taken while both stages are full");

endmodule

@@ sv/mmf_window.sv @@
module mmf_window
    import mmf_pkg::*;
#(
    parameter int unsigned WINDOW = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  sample_t                  sample,
    input  sample_t                  floor_value,
    input  logic                     advance,
    output sample_t [WINDOW-1:0]     window,
    output stage_t                   stage
);

    localparam int unsigned FILL_W = $clog2(WINDOW + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW - 1);

    sample_t [WINDOW-1:0] win_reg;
    sample_t [WINDOW-1:0] win_next;
    logic    [FILL_W-1:0] fill_reg;
    logic    [FILL_W-1:0] fill_next;
    stage_t               stage_reg;
    stage_t               stage_next;
    logic                 term;

    assign term = $signed(sample) < $signed(floor_value);

    always_comb begin
        win_next   = win_reg;
        fill_next  = fill_reg;
        stage_next = stage_reg;
        if (advance) begin
            stage_next.valid = 1'b0;
        end
        if (accept) begin
            if (term) begin
                win_next         = '0;
                fill_next        = '0;
                stage_next.valid = 1'b1;
                stage_next.last  = 1'b1;
                stage_next.data  = sample;
            end else begin
                for (int i = 0; i < WINDOW - 1; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[WINDOW-1] = sample;
                if (fill_reg < FILL_FULL) begin
                    fill_next = fill_reg + 1'b1;
                end
                stage_next.valid = fill_reg >= FILL_LAST;
                stage_next.last  = 1'b0;
                stage_next.data  = sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            fill_reg  <= '0;
            stage_reg <= '0;
        end else begin
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            stage_reg <= stage_next;
        end
    end

    assign window = win_reg;
    assign stage  = stage_reg;

endmodule

@@ sv/mmf_median.sv @@
module mmf_median
    import mmf_pkg::*;
#(
    parameter int unsigned WINDOW = 5
) (
    input  sample_t [WINDOW-1:0] window,
    output sample_t              median
);

    localparam int unsigned RANK_W = $clog2(WINDOW);
    localparam logic [RANK_W-1:0] RANK_HI = RANK_W'(WINDOW / 2);
    localparam logic [RANK_W-1:0] RANK_LO = RANK_W'((WINDOW - 1) / 2);

    logic [WINDOW-1:0][RANK_W-1:0] rank;
    sample_t                       pick_hi;
    sample_t                       pick_lo;
    logic signed [DATA_W:0]        pair_sum;

    // Each entry's rank counts the entries ahead of it in sorted order, with
    // ties broken by position so that the ranks form a permutation.
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                if (j != i) begin
                    if (($signed(window[j]) < $signed(window[i])) ||
                        ((window[j] == window[i]) && (j < i))) begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        pick_hi = '0;
        pick_lo = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (rank[i] == RANK_HI) begin
                pick_hi = pick_hi | window[i];
            end
            if (rank[i] == RANK_LO) begin
                pick_lo = pick_lo | window[i];
            end
        end
    end

    // For an odd window both picks are the same entry, and the floored mean
    // of a value with itself is that value.
    assign pair_sum = {pick_lo[DATA_W-1], pick_lo} + {pick_hi[DATA_W-1], pick_hi};
    assign median   = pair_sum[DATA_W:1];

endmodule

@@ bench/tb_moving_median_filter_top.sv @@
module tb_moving_median_filter_top;
    import mmf_pkg::*;

    localparam int WIN = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct {
        sample_t value;
        logic    end_of_run;
    } median_result_t;

    class median_scoreboard;
        sample_t        floor_val;
        sample_t        win[WIN];
        int unsigned    fill;
        median_result_t due[$];
        int             errors;
        int             samples_in;
        int             medians;
        int             terminators;
        int             results_seen;

        function new();
            floor_val = FLOOR_RESET;
            foreach (win[i]) win[i] = '0;
            fill = 0;
            errors = 0;
            samples_in = 0;
            medians = 0;
            terminators = 0;
            results_seen = 0;
        endfunction

        function void set_floor(sample_t f);
            floor_val = f;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function int window_median();
            int v[WIN];
            int key;
            int j;
            int sum;
            foreach (win[i]) v[i] = win[i];
            for (int a = 1; a < WIN; a++) begin
                key = v[a];
                j = a - 1;
                while (j >= 0 && v[j] > key) begin
                    v[j + 1] = v[j];
                    j--;
                end
                v[j + 1] = key;
            end
            if (WIN % 2 != 0) begin
                return v[WIN / 2];
            end
            sum = v[WIN / 2 - 1] + v[WIN / 2];
            return sum >>> 1;
        endfunction

        function void note_sample(sample_t s);
            median_result_t r;
            samples_in++;
            if (s < floor_val) begin
                foreach (win[i]) win[i] = '0;
                fill = 0;
                r.value = s;
                r.end_of_run = 1'b1;
                due.push_back(r);
                terminators++;
                return;
            end
            for (int k = 0; k < WIN - 1; k++) win[k] = win[k + 1];
            win[WIN - 1] = s;
            if (fill < WIN) fill++;
            if (fill < WIN) return;
            r.value = sample_t'(window_median());
            r.end_of_run = 1'b0;
            due.push_back(r);
            medians++;
        endfunction

        function void check_result(sample_t value, logic end_of_run);
            median_result_t r;
            results_seen++;
            if (due.size() == 0) begin
                $display("%0t: unexpected result beat, value %0d end_of_run %0b",
                         $time, value, end_of_run);
                errors++;
                return;
            end
            r = due.pop_front();
            if (value !== r.value) begin
                $display("%0t: value mismatch, expected %0d, actual %0d",
                         $time, r.value, value);
                errors++;
            end
            if (end_of_run !== r.end_of_run) begin
                $display("%0t: end_of_run mismatch, expected %0b, actual %0b",
                         $time, r.end_of_run, end_of_run);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    median_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;
    int floors_used = 0;

    moving_median_filter_top #(
        .WINDOW(WIN)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_sample(sample_t'(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(sample_t'(m_tdata), m_tlast);
        end
    end

    // The receiver alternates between open, stalled and choppy stretches, and
    // once holds off long enough for the block to fill and stall its input.
    initial begin
        int mode;
        int len;
        bit held;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && sb.results_seen >= 100) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0, 1: begin
                        m_tready <= 1'b1;
                    end
                    2: begin
                        m_tready <= (i < 3) ? 1'b0 : 1'b1;
                    end
                    default: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                endcase
                @(posedge aclk);
            end
        end
    end

    task automatic push_sample(input sample_t x);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= x;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_floor(input sample_t f);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= f;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_floor(f);
        floors_used++;
    endtask

    function automatic sample_t pick_sample(input sample_t f);
        int lo;
        int span;
        lo = f;
        if (lo > -32768 && $urandom_range(0, 15) == 0) begin
            return sample_t'(-32768 + int'($urandom_range(0, lo - 1 + 32768)));
        end
        span = 32767 - lo;
        if ($urandom_range(0, 3) == 0 && span > 15) begin
            span = 15;
        end
        return sample_t'(lo + int'($urandom_range(0, span)));
    endfunction

    initial begin
        sample_t directed[$];
        sample_t phase_floors[5];

        directed = '{-16'sd4371, -16'sd32768, -16'sd4370, 16'sd32767, 16'sd32767,
                     -16'sd4370, 16'sd0, 16'sd1, -16'sd1, 16'sd100,
                     16'sd5, 16'sd6, -16'sd5000,
                     16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                     -16'sd4370, -16'sd4370, -16'sd4370, -16'sd4370, -16'sd4370};
        phase_floors = '{-16'sd32768, 16'sd32767, 16'sd0, sample_t'($urandom_range(0, 65535)),
                         FLOOR_RESET};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        floors_used = 1;
        foreach (directed[i]) push_sample(directed[i]);
        drain();

        foreach (phase_floors[p]) begin
            write_floor(phase_floors[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                push_sample(pick_sample(phase_floors[p]));
            end
            drain();
        end

        $display("Run covered %0d samples giving %0d medians and %0d terminator echoes,",
                 sb.samples_in, sb.medians, sb.terminators);
        $display("across %0d floor settings with bursty input and stalled output.",
                 floors_used);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ moving_median_filter_top.f @@
sv/mmf_pkg.sv
sv/mmf_window.sv
sv/mmf_median.sv
sv/moving_median_filter_top.sv
bench/tb_moving_median_filter_top.sv
